// ----- rtl/core/bpc_pkg.sv -----
package bpc_pkg;

    // default timing values, used where a timing register holds zero
    localparam logic [15:0] DEF_DEBOUNCE   = 16'd20;
    localparam logic [15:0] DEF_SHORT      = 16'd600;
    localparam logic [15:0] DEF_LONG       = 16'd1500;
    localparam logic        DEF_ACTIVE_LOW = 1'b1;

    localparam logic [6:0]  PCT_FULL = 7'd100;

    // configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_SHORT      = 2'd1;
    localparam logic [1:0] CFG_LONG       = 2'd2;
    localparam logic [1:0] CFG_ACTIVE_LOW = 2'd3;

    // command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // progress division: numerator is at most 65535 * 100, quotient below 100
    localparam int NUM_W = 23;
    localparam int QUO_W = 7;
    localparam int BIT_W = 3;

    typedef enum logic [2:0] {
        EV_DOWN    = 3'd0,
        EV_SHORT   = 3'd1,
        EV_TICK    = 3'd2,
        EV_CONFIRM = 3'd3,
        EV_CANCEL  = 3'd4,
        EV_UP      = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_DEB_PRESS = 3'd1,
        ST_PRESSED   = 3'd2,
        ST_LONG_OK   = 3'd3,
        ST_DEB_REL   = 3'd4
    } t_state;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_DONE = 2'd2
    } t_bstate;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] press_duration;
        logic [6:0]  charge_pct;
        logic        last_event;
    } t_out_item;

    // one event waiting for the back end
    typedef struct packed {
        logic [2:0]       kind;
        logic [31:0]      dur;
        logic [6:0]       prog;
        logic             last;
        logic             need_div;
        logic [NUM_W-1:0] num;
        logic [15:0]      span;
    } t_cmd;

    // up to two commands written per accepted request
    typedef struct packed {
        logic push0;
        logic push1;
        t_cmd cmd0;
        t_cmd cmd1;
    } t_q_wr;

endpackage

// ----- rtl/core/bpc_front.sv -----
module bpc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  bpc_pkg::t_in_item i_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_q_room,
    output bpc_pkg::t_q_wr    o_q_wr
);
    import bpc_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_entry, n_entry;
    logic [31:0] r_start, n_start;
    logic        r_charging, n_charging;

    logic [15:0] r_deb, r_sp, r_lp;
    logic        r_active_low;

    logic        accept;
    logic        pressed;
    logic [15:0] deb, sp, lp;
    logic [31:0] now, dur, elapsed;
    logic        dur_ge_sp, dur_ge_lp;
    logic [15:0] cur, span;

    function automatic t_cmd mk_cmd(input logic [2:0] kind, input logic [31:0] d,
                                    input logic [6:0] p, input logic l);
        t_cmd c;
        c          = '0;
        c.kind     = kind;
        c.dur      = d;
        c.prog     = p;
        c.last     = l;
        return c;
    endfunction

    assign o_full      = !i_q_room;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && i_q_room;

    assign now     = i_item.time_ms;
    assign pressed = r_active_low ? !i_item.pin_level : i_item.pin_level;
    assign deb     = (r_deb == 16'd0) ? DEF_DEBOUNCE : r_deb;
    assign sp      = (r_sp  == 16'd0) ? DEF_SHORT    : r_sp;
    assign lp      = (r_lp  == 16'd0) ? DEF_LONG     : r_lp;
    assign dur     = now - r_start;
    assign elapsed = now - r_entry;

    assign dur_ge_sp = dur >= {16'h0, sp};
    assign dur_ge_lp = dur >= {16'h0, lp};
    // inside the charging window both fit in 16 bits
    assign cur       = dur[15:0] - sp;
    assign span      = lp - sp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deb        <= DEF_DEBOUNCE;
            r_sp         <= DEF_SHORT;
            r_lp         <= DEF_LONG;
            r_active_low <= DEF_ACTIVE_LOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_deb        <= i_cfg_data;
                CFG_SHORT:      r_sp         <= i_cfg_data;
                CFG_LONG:       r_lp         <= i_cfg_data;
                CFG_ACTIVE_LOW: r_active_low <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_entry    <= '0;
            r_start    <= '0;
            r_charging <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_entry    <= n_entry;
            r_start    <= n_start;
            r_charging <= n_charging;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_entry    = r_entry;
        n_start    = r_start;
        n_charging = r_charging;
        o_q_wr     = '0;
        if (accept) begin
            case (r_state)
                ST_IDLE: begin
                    if (pressed) begin
                        n_entry = now;
                        n_state = ST_DEB_PRESS;
                    end
                end
                ST_DEB_PRESS: begin
                    if (!pressed) begin
                        n_state = ST_IDLE;
                    end else if (elapsed >= {16'h0, deb}) begin
                        n_start      = now;
                        n_charging   = 1'b0;
                        n_state      = ST_PRESSED;
                        o_q_wr.push0 = 1'b1;
                        o_q_wr.cmd0  = mk_cmd(EV_DOWN, 32'd0, 7'd0, 1'b1);
                    end
                end
                ST_PRESSED: begin
                    if (pressed) begin
                        if (dur_ge_sp && !dur_ge_lp) begin
                            n_charging           = 1'b1;
                            o_q_wr.push0         = 1'b1;
                            o_q_wr.cmd0          = mk_cmd(EV_TICK, dur, 7'd0, 1'b1);
                            o_q_wr.cmd0.need_div = 1'b1;
                            o_q_wr.cmd0.num      = {7'h0, cur} * 23'd100;
                            o_q_wr.cmd0.span     = span;
                        end else if (dur_ge_lp) begin
                            n_state      = ST_LONG_OK;
                            o_q_wr.push0 = 1'b1;
                            o_q_wr.cmd0  = mk_cmd(EV_CONFIRM, dur, PCT_FULL, 1'b1);
                        end
                    end else begin
                        n_entry      = now;
                        n_state      = ST_DEB_REL;
                        o_q_wr.push0 = 1'b1;
                        if (!dur_ge_sp || r_charging) begin
                            // short press or cancel, then up
                            o_q_wr.cmd0  = mk_cmd(dur_ge_sp ? EV_CANCEL : EV_SHORT,
                                                  dur, 7'd0, 1'b0);
                            o_q_wr.push1 = 1'b1;
                            o_q_wr.cmd1  = mk_cmd(EV_UP, dur, 7'd0, 1'b1);
                        end else begin
                            o_q_wr.cmd0 = mk_cmd(EV_UP, dur, 7'd0, 1'b1);
                        end
                    end
                end
                ST_LONG_OK: begin
                    if (!pressed) begin
                        n_entry      = now;
                        n_state      = ST_DEB_REL;
                        o_q_wr.push0 = 1'b1;
                        o_q_wr.cmd0  = mk_cmd(EV_UP, dur, PCT_FULL, 1'b1);
                    end
                end
                ST_DEB_REL: begin
                    if (pressed) begin
                        n_entry = now;
                    end else if (elapsed >= {16'h0, deb}) begin
                        n_state = ST_IDLE;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/bpc_cmd_queue.sv -----
module bpc_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bpc_pkg::t_q_wr i_q_wr,
    output logic           o_room,
    input  logic           i_pop,
    output logic           o_empty,
    output bpc_pkg::t_cmd  o_head
);
    import bpc_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic [Q_AW-1:0] wr_ptr1;
    logic            do_pop;

    assign do_pop  = i_pop && !o_empty;
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    // room for the largest group of events one request can make
    assign o_room  = r_count <= Q_CW'(Q_DEPTH - 2);
    assign wr_ptr1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_count = r_count + Q_CW'(i_q_wr.push0) + Q_CW'(i_q_wr.push1) - Q_CW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_q_wr.push0) begin
            r_mem[r_wr_ptr] <= i_q_wr.cmd0;
        end
        if (i_q_wr.push1) begin
            r_mem[wr_ptr1] <= i_q_wr.cmd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_AW'(i_q_wr.push0) + Q_AW'(i_q_wr.push1);
            r_rd_ptr <= r_rd_ptr + Q_AW'(do_pop);
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("command queue count beyond depth");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_wr.push1 |-> i_q_wr.push0)
        else $error("second command written without the first");

endmodule

// ----- rtl/core/bpc_back.sv -----
module bpc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  bpc_pkg::t_cmd      i_q_head,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output bpc_pkg::t_out_item o_item
);
    import bpc_pkg::*;

    t_bstate          r_bstate, n_bstate;
    t_cmd             r_cmd, n_cmd;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic             slot_free;
    logic [NUM_W-1:0] trial;

    assign o_empty   = !r_out_valid;
    assign o_item    = r_out;
    assign slot_free = !r_out_valid || i_pop;
    assign trial     = {7'h0, r_cmd.span} << r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_bstate    <= n_bstate;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_bit <= n_bit;
        r_out <= n_out;
    end

    always_comb begin
        n_bstate    = r_bstate;
        n_cmd       = r_cmd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_q_pop     = 1'b0;
        case (r_bstate)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head.need_div) begin
                        o_q_pop  = 1'b1;
                        n_cmd    = i_q_head;
                        n_rem    = i_q_head.num;
                        n_quo    = '0;
                        n_bit    = BIT_W'(QUO_W - 1);
                        n_bstate = BK_DIV;
                    end else if (slot_free) begin
                        o_q_pop              = 1'b1;
                        n_out_valid          = 1'b1;
                        n_out.event_kind     = i_q_head.kind;
                        n_out.press_duration = i_q_head.dur;
                        n_out.charge_pct     = i_q_head.prog;
                        n_out.last_event     = i_q_head.last;
                    end
                end
            end
            BK_DIV: begin
                // restoring division, one quotient bit per cycle
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                    n_quo = r_quo | (QUO_W'(1) << r_bit);
                end
                if (r_bit == '0) begin
                    n_bstate = BK_DONE;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            BK_DONE: begin
                if (slot_free) begin
                    n_out_valid          = 1'b1;
                    n_out.event_kind     = r_cmd.kind;
                    n_out.press_duration = r_cmd.dur;
                    n_out.charge_pct     = r_quo;
                    n_out.last_event     = r_cmd.last;
                    n_bstate             = BK_IDLE;
                end
            end
            default: begin
                n_bstate = BK_IDLE;
            end
        endcase
    end

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !i_q_empty)
        else $error("command popped from an empty queue");

    a_span_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == BK_DIV) |-> (r_cmd.span != 16'd0))
        else $error("progress division by zero span");

    a_tick_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_kind == EV_TICK) |-> (r_out.charge_pct < PCT_FULL))
        else $error("tick progress reached full charge");

endmodule

// ----- rtl/core/button_press_classifier.sv -----
// button press classifier: each request is one poll sample of the button pin (raw level
// and a free-running millisecond timestamp). the front end debounces the pin and runs the
// press state machine in the cycle the sample is taken, and queues zero, one or two events
// (down, short press, long tick, long confirm, cancel, up; the last event of a sample has
// last_event set). the back end turns events into results; a long tick computes its
// percent progress in a restoring divider at one quotient bit per cycle, while every other
// event passes straight to the result slot. samples are taken one per cycle while
// the four-entry event queue has room for two more events; during long-press charging the
// divider limits the sustained sample rate. the timing registers take their defaults
// (20, 600 and 1500 ms) when written as zero; cfg_ready is always high.
module button_press_classifier (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample requests
    input  logic               push,
    output logic               full,
    input  bpc_pkg::t_in_item  i_item,
    // event results
    output logic               empty,
    input  logic               pop,
    output bpc_pkg::t_out_item o_item,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import bpc_pkg::*;

    t_q_wr q_wr;
    logic  q_room;
    logic  q_empty;
    logic  q_pop;
    t_cmd  q_head;

    // front end: debounce, press state machine and event classification
    bpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_room    (q_room),
        .o_q_wr      (q_wr)
    );

    // short event queue so either side can stall on its own
    bpc_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_wr  (q_wr),
        .o_room  (q_room),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // back end: progress divider and registered result slot
    bpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_item)
    );

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int N_PHASES        = 8;

    // a script row either types its events in or leaves them to the predictor
    localparam int FROM_PREDICTOR = -1;
    localparam t_out_item NO_EV = '0;

    typedef struct {
        logic       pin;
        logic [31:0] ms;
        int         n_typed;
        t_out_item  ev0;
        t_out_item  ev1;
    } t_script_row;

    typedef struct {
        logic [15:0] deb;
        logic [15:0] sp;
        logic [15:0] lp;
        logic        al;
    } t_setting;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      push        = 1'b0;
    logic      full;
    t_in_item  i_item      = '0;
    logic      empty;
    logic      pop         = 1'b0;
    t_out_item o_item;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    button_press_classifier DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow copy of the classifier: registers, press state machine and
    // the events of the latest request
    // ------------------------------------------------------------------
    logic [15:0] cfg_deb   = DEF_DEBOUNCE;
    logic [15:0] cfg_short = DEF_SHORT;
    logic [15:0] cfg_long  = DEF_LONG;
    logic        cfg_al    = DEF_ACTIVE_LOW;

    t_state      btn_state = ST_IDLE;
    logic [31:0] entry_ms  = '0;
    logic [31:0] start_ms  = '0;
    logic        charging  = 1'b0;

    t_out_item   step_ev[2];
    int          step_n;

    // events still owed by the block, oldest first
    t_out_item   pending_events[$];

    int          n_errors  = 0;
    int          n_sent    = 0;
    int          n_results = 0;
    int          n_cycles  = 0;
    int          pop_hold  = 0;
    bit          calm      = 1'b0;   // no pick_gap idling on either side while set
    logic [31:0] ms_now    = '0;

    task automatic add_event(t_event kind, logic [31:0] dur, logic [6:0] pct, logic last);
        t_out_item e;
        e.event_kind     = kind;
        e.press_duration = dur;
        e.charge_pct     = pct;
        e.last_event     = last;
        step_ev[step_n]  = e;
        step_n++;
    endtask

    // advances the shadow state by one poll and fills step_ev
    task automatic classify_sample(t_in_item s);
        logic        held;
        logic [31:0] deb_ms, short_ms, long_ms, dur, pct;
        held     = cfg_al ? ~s.pin_level : s.pin_level;
        // zero in a timing register selects its default
        deb_ms   = {16'd0, (cfg_deb   == '0) ? DEF_DEBOUNCE : cfg_deb};
        short_ms = {16'd0, (cfg_short == '0) ? DEF_SHORT    : cfg_short};
        long_ms  = {16'd0, (cfg_long  == '0) ? DEF_LONG     : cfg_long};
        dur      = s.time_ms - start_ms;
        step_n   = 0;
        case (btn_state)
            ST_IDLE: begin
                if (held) begin
                    entry_ms  = s.time_ms;
                    btn_state = ST_DEB_PRESS;
                end
            end
            ST_DEB_PRESS: begin
                if (!held) begin
                    btn_state = ST_IDLE;
                end else if (s.time_ms - entry_ms >= deb_ms) begin
                    start_ms  = s.time_ms;
                    charging  = 1'b0;
                    btn_state = ST_PRESSED;
                    add_event(EV_DOWN, '0, '0, 1'b1);
                end
            end
            ST_PRESSED: begin
                if (held) begin
                    if (dur >= short_ms && dur < long_ms) begin
                        // charge progress, truncated toward zero
                        pct      = ((dur - short_ms) * 32'd100) / (long_ms - short_ms);
                        charging = 1'b1;
                        add_event(EV_TICK, dur, pct[6:0], 1'b1);
                    end else if (dur >= long_ms) begin
                        add_event(EV_CONFIRM, dur, PCT_FULL, 1'b1);
                        btn_state = ST_LONG_OK;
                    end
                end else begin
                    if (dur < short_ms) begin
                        add_event(EV_SHORT, dur, '0, 1'b0);
                    end else if (charging) begin
                        add_event(EV_CANCEL, dur, '0, 1'b0);
                    end
                    add_event(EV_UP, dur, '0, 1'b1);
                    entry_ms  = s.time_ms;
                    btn_state = ST_DEB_REL;
                end
            end
            ST_LONG_OK: begin
                if (!held) begin
                    add_event(EV_UP, dur, PCT_FULL, 1'b1);
                    entry_ms  = s.time_ms;
                    btn_state = ST_DEB_REL;
                end
            end
            ST_DEB_REL: begin
                if (held) begin
                    entry_ms = s.time_ms;      // bounce restarts the release window
                end else if (s.time_ms - entry_ms >= deb_ms) begin
                    btn_state = ST_IDLE;
                end
            end
            default: btn_state = ST_IDLE;
        endcase
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // one poll request; push stays high into the next call unless a gap follows
    task automatic send_sample(t_in_item it, int n_typed, t_out_item ev0, t_out_item ev1);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        n_sent++;
        classify_sample(it);
        if (n_typed == FROM_PREDICTOR) begin
            for (int k = 0; k < step_n; k++) pending_events.push_back(step_ev[k]);
        end else begin
            if (n_typed > 0) pending_events.push_back(ev0);
            if (n_typed > 1) pending_events.push_back(ev1);
        end
    endtask

    // holds one pin level for at least span_ms (at most 40 samples), with the odd bounce mixed in
    task automatic hold_level(logic lvl, int unsigned span_ms);
        int unsigned step_ms, elapsed, last, d;
        int          cnt;
        logic        glitch;
        t_in_item    it;
        step_ms = span_ms / $urandom_range(2, 12) + 1;
        elapsed = 0;
        cnt     = 0;
        do begin
            glitch = ($urandom_range(0, 15) == 0);
            it     = '{lvl ^ glitch, ms_now};
            send_sample(it, FROM_PREDICTOR, NO_EV, NO_EV);
            last    = elapsed;
            d       = $urandom_range(0, 2 * step_ms);
            ms_now += d;
            elapsed += d;
            cnt++;
        end while (last < span_ms && cnt < 40);
    endtask

    // one press and release aimed at a duration class, or a burst of noise
    task automatic play_gesture();
        int unsigned deb_ms, sp_ms, lp_ms, hold;
        int          sel;
        logic        down_lvl;
        t_in_item    it;
        deb_ms   = 32'((cfg_deb   == '0) ? DEF_DEBOUNCE : cfg_deb);
        sp_ms    = 32'((cfg_short == '0) ? DEF_SHORT    : cfg_short);
        lp_ms    = 32'((cfg_long  == '0) ? DEF_LONG     : cfg_long);
        down_lvl = ~cfg_al;
        sel      = $urandom_range(0, 7);
        if (sel == 0) begin
            // random levels and jumps of any size, timestamp wrap included
            repeat ($urandom_range(1, 6)) begin
                ms_now += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 50);
                it = '{1'($urandom), ms_now};
                send_sample(it, FROM_PREDICTOR, NO_EV, NO_EV);
            end
        end else begin
            case (sel)
                1, 2:    hold = $urandom_range(0, sp_ms);
                3, 4:    hold = $urandom_range(sp_ms, lp_ms);
                5, 6:    hold = lp_ms + $urandom_range(0, lp_ms / 2);
                default: hold = $urandom_range(0, 2 * lp_ms);
            endcase
            hold_level(down_lvl, deb_ms + hold);
            hold_level(~down_lvl, deb_ms + $urandom_range(0, deb_ms));
        end
    endtask

    // lets every owed event come out, then gives the block time to go quiet
    task automatic settle();
        push <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // valid is left high here; the caller lowers it after the last write
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE:   cfg_deb   = val;
            CFG_SHORT:      cfg_short = val;
            CFG_LONG:       cfg_long  = val;
            CFG_ACTIVE_LOW: cfg_al    = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(t_setting s);
        logic [15:0] al_word;
        // upper bits of the polarity write are junk and must be dropped
        al_word    = 16'($urandom);
        al_word[0] = s.al;
        write_reg(CFG_DEBOUNCE, s.deb);
        write_reg(CFG_SHORT, s.sp);
        write_reg(CFG_LONG, s.lp);
        write_reg(CFG_ACTIVE_LOW, al_word);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // directed script, reset settings: 20 / 600 / 1500 ms, active low
    // ------------------------------------------------------------------
    t_script_row press_script[27] = '{
        // short press, then a bounce inside the release window
        '{1'b0, 32'd100,  0, NO_EV, NO_EV},
        '{1'b0, 32'd120,  1, '{EV_DOWN, 32'd0, 7'd0, 1'b1}, NO_EV},
        '{1'b1, 32'd400,  2, '{EV_SHORT, 32'd280, 7'd0, 1'b0},
                             '{EV_UP, 32'd280, 7'd0, 1'b1}},
        '{1'b0, 32'd415,  0, NO_EV, NO_EV},
        '{1'b1, 32'd440,  0, NO_EV, NO_EV},
        // long press: ticks from 0 percent, then confirm and up at full charge
        '{1'b0, 32'd1000, 0, NO_EV, NO_EV},
        '{1'b0, 32'd1020, 1, '{EV_DOWN, 32'd0, 7'd0, 1'b1}, NO_EV},
        '{1'b0, 32'd1620, 1, '{EV_TICK, 32'd600, 7'd0, 1'b1}, NO_EV},
        '{1'b0, 32'd2070, 1, '{EV_TICK, 32'd1050, 7'd50, 1'b1}, NO_EV},
        '{1'b0, 32'd2519, FROM_PREDICTOR, NO_EV, NO_EV},
        '{1'b0, 32'd2520, 1, '{EV_CONFIRM, 32'd1500, 7'd100, 1'b1}, NO_EV},
        '{1'b1, 32'd3100, 1, '{EV_UP, 32'd2080, 7'd100, 1'b1}, NO_EV},
        '{1'b1, 32'd3120, 0, NO_EV, NO_EV},
        // release while charging gives cancel then up
        '{1'b0, 32'd4000, 0, NO_EV, NO_EV},
        '{1'b0, 32'd4020, 1, '{EV_DOWN, 32'd0, 7'd0, 1'b1}, NO_EV},
        '{1'b0, 32'd4700, FROM_PREDICTOR, NO_EV, NO_EV},
        '{1'b1, 32'd4800, 2, '{EV_CANCEL, 32'd780, 7'd0, 1'b0},
                             '{EV_UP, 32'd780, 7'd0, 1'b1}},
        '{1'b1, 32'd4820, 0, NO_EV, NO_EV},
        // past the short limit with no charging: up alone
        '{1'b0, 32'd5000, 0, NO_EV, NO_EV},
        '{1'b0, 32'd5020, 1, '{EV_DOWN, 32'd0, 7'd0, 1'b1}, NO_EV},
        '{1'b1, 32'd5700, 1, '{EV_UP, 32'd680, 7'd0, 1'b1}, NO_EV},
        '{1'b1, 32'd5720, 0, NO_EV, NO_EV},
        // timestamp wraps through zero during debounce and while held
        '{1'b0, 32'hFFFF_FFF0, 0, NO_EV, NO_EV},
        '{1'b0, 32'h0000_0004, 1, '{EV_DOWN, 32'd0, 7'd0, 1'b1}, NO_EV},
        '{1'b0, 32'hFFFF_FFFF, FROM_PREDICTOR, NO_EV, NO_EV},
        '{1'b1, 32'h0000_0000, FROM_PREDICTOR, NO_EV, NO_EV},
        '{1'b1, 32'h0000_0020, 0, NO_EV, NO_EV}
    };

    // fixed register settings, extremes first; later phases draw at random
    t_setting setting_plan[5] = '{
        '{16'd0,     16'd0,     16'd0,     1'b0},   // all defaults, active high
        '{16'd1,     16'd1,     16'hFFFF,  1'b1},   // widest charge window
        '{16'hFFFF,  16'hFFFF,  16'd1,     1'b0},   // short limit above long limit
        '{16'd5,     16'd100,   16'd100,   1'b1},   // equal limits, no ticks
        '{16'd10,    16'd50,    16'd400,   1'b0}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_setting s;
        t_in_item it;
        int       target;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (press_script[r]) begin
            it = '{press_script[r].pin, press_script[r].ms};
            send_sample(it, press_script[r].n_typed, press_script[r].ev0,
                        press_script[r].ev1);
        end
        settle();

        ms_now = 32'd1000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph < 5) begin
                s = setting_plan[ph];
            end else begin
                s.deb = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
                s.sp  = 16'($urandom_range(0, 2000));
                s.lp  = 16'($urandom_range(0, 4000));
                s.al  = 1'($urandom);
            end
            program_regs(s);
            calm   = ($urandom_range(0, 3) == 0);
            target = n_sent + ITEMS_PER_PHASE;
            while (n_sent < target) play_gesture();
            settle();
        end

        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: check each popped event and drive pop with random stalls
    // ------------------------------------------------------------------
    task automatic report_field(string what, logic [31:0] want, logic [31:0] got);
        n_errors++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic check_event(t_out_item got);
        t_out_item want;
        if (pending_events.size() == 0) begin
            n_errors++;
            $display("%0t: event kind %0d popped with nothing expected, expected none",
                     $time, got.event_kind);
        end else begin
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_field("event_kind", 32'(want.event_kind), 32'(got.event_kind));
            if (got.press_duration !== want.press_duration)
                report_field("press_duration", want.press_duration, got.press_duration);
            if (got.charge_pct !== want.charge_pct)
                report_field("charge_pct", 32'(want.charge_pct), 32'(got.charge_pct));
            if (got.last_event !== want.last_event)
                report_field("last_event", 32'(want.last_event), 32'(got.last_event));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            check_event(o_item);
            n_results++;
            // long hold-off so the event queue fills and full rises
            if (n_results == 150 || n_results == 400) pop_hold = $urandom_range(250, 450);
        end
        if (pop_hold == 0 && !calm && $urandom_range(0, 3) == 0) pop_hold = pick_gap();
        if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

endmodule
